### sv/union_find_with_set_extrema_defines.svh
// Assertion macros shared by the union-find block.
// Uses the aclk and aresetn names of the including module; no other dependencies.
`ifndef UNION_FIND_WITH_SET_EXTREMA_DEFINES_SVH
`define UNION_FIND_WITH_SET_EXTREMA_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define UFSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define UFSE_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define UFSE_ASSERT(lbl, prop, msg)
`define UFSE_ASSERT_RST(lbl, prop, msg)
`endif

`endif

### sv/ufse_pkg.sv
// Shared constants and controller/datapath command and status types.
// No dependencies.
package ufse_pkg;

    localparam int DEF_NUM_ELEMS = 1024;
    localparam int IN_W          = 10;
    localparam int IDX_OUT_W     = 10;
    localparam int SUM_OUT_W     = 19;
    localparam int SIZE_W        = 11;
    localparam int SUM_W         = 20;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 104;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic find_adv;
        logic set_root;
        logic start_comp;
        logic comp_wr;
        logic next_operand;
        logic rd_info_b;
        logic cap_info_a;
        logic cap_info_b;
        logic merge;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic parent_is_cur;
        logic cur_is_root;
        logic sel_b;
        logic out_free;
    } status_t;

endpackage

### sv/ufse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### sv/ufse_ctrl.sv
// Sequencer for the union-find block: clearing pass, root walks,
// path compression, set record reads and the merge. Uses ufse_pkg.
module ufse_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ufse_pkg::status_t st,
    output ufse_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        CLEAR, IDLE, FIND_RD, FIND_CHK, COMP_RD, COMP_WR,
        INFO_A, INFO_B, INFO_C, MERGE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            CLEAR: begin
                cmd.clr_step = 1'b1;
                if (st.clr_last) state_next = IDLE;
            end
            IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = FIND_RD;
                end
            end
            FIND_RD: state_next = FIND_CHK;
            FIND_CHK: begin
                if (st.parent_is_cur) begin
                    cmd.set_root   = 1'b1;
                    cmd.start_comp = 1'b1;
                    state_next     = COMP_RD;
                end else begin
                    cmd.find_adv = 1'b1;
                    state_next   = FIND_RD;
                end
            end
            COMP_RD: begin
                if (!st.cur_is_root) begin
                    state_next = COMP_WR;
                end else if (st.sel_b) begin
                    state_next = INFO_A;
                end else begin
                    cmd.next_operand = 1'b1;
                    state_next       = FIND_RD;
                end
            end
            COMP_WR: begin
                cmd.comp_wr = 1'b1;
                state_next  = COMP_RD;
            end
            INFO_A: state_next = INFO_B;
            INFO_B: begin
                cmd.rd_info_b  = 1'b1;
                cmd.cap_info_a = 1'b1;
                state_next     = INFO_C;
            end
            INFO_C: begin
                cmd.cap_info_b = 1'b1;
                state_next     = MERGE;
            end
            MERGE: begin
                if (st.out_free) begin
                    cmd.merge  = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/ufse_dp.sv
// Datapath of the union-find block: parent and set record memories,
// walk registers, merge arithmetic and the output register.
// Uses ufse_pkg, ufse_ram and the assertion macro header.
`include "union_find_with_set_extrema_defines.svh"

module ufse_dp #(
    parameter int NUM_ELEMS = ufse_pkg::DEF_NUM_ELEMS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ufse_pkg::cmd_t                   cmd,
    output ufse_pkg::status_t                st,
    input  logic [ufse_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ufse_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);

    localparam int AW     = $clog2(NUM_ELEMS);
    localparam int SUM_W  = ufse_pkg::SUM_W;
    localparam int SIZE_W = ufse_pkg::SIZE_W;
    localparam int IW     = SIZE_W + 2 * AW + SUM_W;
    localparam logic [AW-1:0] LAST = AW'(NUM_ELEMS - 1);
    localparam int PAD_W  = ufse_pkg::M_TDATA_W - 6 * ufse_pkg::IDX_OUT_W
                            - 2 * ufse_pkg::SUM_OUT_W;

    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] a_reg, b_reg, cur_reg, root_a_reg, root_b_reg;
    logic          sel_b_reg;
    logic [IW-1:0] info_a_reg, info_b_reg;
    logic          m_tvalid_reg;
    logic [ufse_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic          m_tuser_reg;

    logic [AW-1:0] a_clamp, b_clamp, root_cur;
    logic          p_we, i_we;
    logic [AW-1:0] p_waddr, p_wdata, p_rdata, i_waddr, i_raddr;
    logic [IW-1:0] i_wdata, i_rdata, info_big, info_small, info_new;
    logic          a_big, roots_eq;
    logic [AW-1:0] big_root, small_root;
    logic [SIZE_W-1:0] size_a, size_b;
    logic [AW-1:0] min_big, min_small, max_big, max_small, new_min, new_max;

    // Indices past the last element saturate to it.
    assign a_clamp = (32'(s_tdata[9:0]) >= NUM_ELEMS) ? LAST : AW'(s_tdata[9:0]);
    assign b_clamp = (32'(s_tdata[19:10]) >= NUM_ELEMS) ? LAST : AW'(s_tdata[19:10]);
    assign root_cur = sel_b_reg ? root_b_reg : root_a_reg;
    assign roots_eq = (root_a_reg == root_b_reg);

    assign size_a = info_a_reg[IW-1 -: SIZE_W];
    assign size_b = info_b_reg[IW-1 -: SIZE_W];
    assign a_big  = size_a > size_b;
    assign big_root   = a_big ? root_a_reg : root_b_reg;
    assign small_root = a_big ? root_b_reg : root_a_reg;
    assign info_big   = a_big ? info_a_reg : info_b_reg;
    assign info_small = a_big ? info_b_reg : info_a_reg;
    assign min_big   = info_big[SUM_W+2*AW-1 -: AW];
    assign min_small = info_small[SUM_W+2*AW-1 -: AW];
    assign max_big   = info_big[SUM_W+AW-1 -: AW];
    assign max_small = info_small[SUM_W+AW-1 -: AW];
    assign new_min = (min_small < min_big) ? min_small : min_big;
    assign new_max = (max_small > max_big) ? max_small : max_big;
    assign info_new = {SIZE_W'(info_big[IW-1 -: SIZE_W] + info_small[IW-1 -: SIZE_W]),
                       new_min, new_max,
                       SUM_W'(info_big[SUM_W-1:0] + info_small[SUM_W-1:0])};

    always_comb begin
        p_we    = cmd.clr_step || cmd.comp_wr || (cmd.merge && !roots_eq);
        p_waddr = small_root;
        p_wdata = big_root;
        if (cmd.clr_step) begin
            p_waddr = clr_cnt_reg;
            p_wdata = clr_cnt_reg;
        end else if (cmd.comp_wr) begin
            p_waddr = cur_reg;
            p_wdata = root_cur;
        end
        i_we    = cmd.clr_step || (cmd.merge && !roots_eq);
        i_waddr = cmd.clr_step ? clr_cnt_reg : big_root;
        i_wdata = cmd.clr_step ? {SIZE_W'(1), clr_cnt_reg, clr_cnt_reg, SUM_W'(clr_cnt_reg)}
                               : info_new;
        i_raddr = cmd.rd_info_b ? root_b_reg : root_a_reg;
    end

    ufse_ram #(.WIDTH(AW), .DEPTH(NUM_ELEMS)) u_parent_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (cur_reg),
        .rdata (p_rdata)
    );

    ufse_ram #(.WIDTH(IW), .DEPTH(NUM_ELEMS)) u_info_ram (
        .aclk  (aclk),
        .we    (i_we),
        .waddr (i_waddr),
        .wdata (i_wdata),
        .raddr (i_raddr),
        .rdata (i_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            sel_b_reg    <= 1'b0;
        end else begin
            if (cmd.clr_step) clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (cmd.load) sel_b_reg <= 1'b0;
            if (cmd.next_operand) sel_b_reg <= 1'b1;
            if (cmd.merge) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            a_reg   <= a_clamp;
            b_reg   <= b_clamp;
            cur_reg <= a_clamp;
        end
        if (cmd.find_adv || cmd.comp_wr) cur_reg <= p_rdata;
        if (cmd.set_root) begin
            if (sel_b_reg) begin
                root_b_reg <= cur_reg;
            end else begin
                root_a_reg <= cur_reg;
            end
        end
        if (cmd.start_comp) cur_reg <= sel_b_reg ? b_reg : a_reg;
        if (cmd.next_operand) cur_reg <= b_reg;
        if (cmd.cap_info_a) info_a_reg <= i_rdata;
        if (cmd.cap_info_b) info_b_reg <= i_rdata;
        if (cmd.merge) begin
            m_tdata_reg <= {{PAD_W{1'b0}},
                            ufse_pkg::SUM_OUT_W'(info_b_reg[SUM_W-1:0]),
                            ufse_pkg::SUM_OUT_W'(info_a_reg[SUM_W-1:0]),
                            ufse_pkg::IDX_OUT_W'(info_b_reg[SUM_W+AW-1 -: AW]),
                            ufse_pkg::IDX_OUT_W'(info_b_reg[SUM_W+2*AW-1 -: AW]),
                            ufse_pkg::IDX_OUT_W'(info_a_reg[SUM_W+AW-1 -: AW]),
                            ufse_pkg::IDX_OUT_W'(info_a_reg[SUM_W+2*AW-1 -: AW]),
                            ufse_pkg::IDX_OUT_W'(root_b_reg),
                            ufse_pkg::IDX_OUT_W'(root_a_reg)};
            m_tuser_reg <= !roots_eq;
        end
    end

    assign st.clr_last      = (clr_cnt_reg == LAST);
    assign st.parent_is_cur = (p_rdata == cur_reg);
    assign st.cur_is_root   = (cur_reg == root_cur);
    assign st.sel_b         = sel_b_reg;
    assign st.out_free      = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `UFSE_ASSERT(a_same_set_no_write, (cmd.merge && roots_eq) |-> !i_we, "set record written for same-set request")
    `UFSE_ASSERT(a_valid_from_merge, $rose(m_tvalid_reg) |-> $past(cmd.merge), "result appeared without a merge")
    `UFSE_ASSERT(a_merged_flag, $rose(m_tvalid_reg) |-> (m_tuser_reg == !roots_eq), "merged flag disagrees with roots")
endmodule

### sv/union_find_with_set_extrema.sv
// Union-find engine over NUM_ELEMS elements. After reset the block runs a clearing pass that
// makes every element its own set; s_tready stays low meanwhile.
// Each transfer on the slave side asks to merge the sets of elem_a and elem_b (indices past
// the last element saturate to it). The block walks both parent chains, points every walked
// element at its root, reads both set records and returns one transfer with both roots and
// each set's min, max and sum as they were before the merge; m_tuser is high when the sets
// were distinct and have been joined (smaller under larger, elem_a's root under elem_b's on
// equal sizes). Each parent link walked takes a read and a check, and each link compressed a
// read and a write, as the parent memory has a single read port. Only one request is in work
// at a time, but a finished result waits in an output register while the next request is taken.
// Depends on ufse_pkg, ufse_ctrl and ufse_dp.
module union_find_with_set_extrema #(
    parameter int NUM_ELEMS = ufse_pkg::DEF_NUM_ELEMS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // elem_a [9:0], elem_b [19:10], zero fill above
    input  logic [ufse_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // root_a, root_b, min_a, max_a, min_b, max_b (10 bits each), sum_a, sum_b (19 each)
    output logic [ufse_pkg::M_TDATA_W-1:0] m_tdata,
    // merged
    output logic                           m_tuser
);

    ufse_pkg::cmd_t    cmd;
    ufse_pkg::status_t st;

    ufse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ufse_dp #(.NUM_ELEMS(NUM_ELEMS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### verif/testbench.sv
// Self-checking testbench for the union-find block with per-set min, max and sum.
// Drives merge requests, predicts every result with its own set model; needs ufse_pkg.
module testbench;
    import ufse_pkg::*;

    localparam int NE        = DEF_NUM_ELEMS;
    localparam int NUM_RAND  = 1550;
    localparam int WDOG_MAX  = 20000 + 2 * NE;

    typedef struct packed {
        logic [9:0]  root_a;
        logic [9:0]  root_b;
        logic [9:0]  min_a;
        logic [9:0]  max_a;
        logic [9:0]  min_b;
        logic [9:0]  max_b;
        logic [18:0] sum_a;
        logic [18:0] sum_b;
        logic        merged;
    } merge_report_t;

    typedef struct {
        logic [9:0]    ea;
        logic [9:0]    eb;
        logic          fixed;
        merge_report_t rep;
    } stim_row_t;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    // elem_a [9:0], elem_b [19:10], zero fill above
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    // root_a, root_b, min_a, max_a, min_b, max_b (10 bits each), sum_a, sum_b (19 each)
    logic [M_TDATA_W-1:0] m_tdata;
    // merged
    logic                 m_tuser;

    union_find_with_set_extrema dut (.*);

    always #2 aclk = ~aclk;

    // Predictor state.
    logic [9:0]  link_of [NE];
    logic [10:0] members [NE];
    logic [9:0]  low_of  [NE];
    logic [9:0]  high_of [NE];
    logic [19:0] total_of[NE];

    merge_report_t pending_reports[$];
    int errors = 0;
    int wdog = 0;
    int stall_left = 0;

    function automatic logic [9:0] leader_of(logic [9:0] e);
        logic [9:0] r, cur, nxt;
        r = e;
        while (link_of[r] != r) r = link_of[r];
        cur = e;
        while (cur != r) begin
            nxt = link_of[cur];
            link_of[cur] = r;
            cur = nxt;
        end
        return r;
    endfunction

    function automatic merge_report_t join_sets(logic [9:0] ea, logic [9:0] eb);
        merge_report_t rep;
        logic [9:0] ra, rb, big, sml;
        ra = leader_of(ea);
        rb = leader_of(eb);
        rep.root_a = ra;
        rep.root_b = rb;
        rep.min_a = low_of[ra];
        rep.max_a = high_of[ra];
        rep.min_b = low_of[rb];
        rep.max_b = high_of[rb];
        rep.sum_a = total_of[ra][18:0];
        rep.sum_b = total_of[rb][18:0];
        rep.merged = (ra != rb);
        if (ra != rb) begin
            if (members[ra] > members[rb]) begin
                big = ra; sml = rb;
            end else begin
                big = rb; sml = ra;
            end
            if (low_of[sml] < low_of[big]) low_of[big] = low_of[sml];
            if (high_of[sml] > high_of[big]) high_of[big] = high_of[sml];
            total_of[big] = total_of[big] + total_of[sml];
            members[big] = members[big] + members[sml];
            link_of[sml] = big;
        end
        return rep;
    endfunction

    function automatic merge_report_t lone_pair(int a, int b, bit same);
        merge_report_t rep;
        rep = '{10'(a), 10'(b), 10'(a), 10'(a), 10'(b), 10'(b), 19'(a), 19'(b), !same};
        return rep;
    endfunction

    task automatic send_merge(logic [9:0] ea, logic [9:0] eb, bit fixed, merge_report_t rep);
        merge_report_t want;
        want = join_sets(ea, eb);
        if (fixed && want != rep) begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees with predictor: %h vs %h", rep, want);
        end
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 3))
                @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {4'b0, eb, ea};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_reports = {pending_reports, want};
    endtask

    // Result side: random stalls, compare against the oldest prediction.
    always @(posedge aclk) begin
        merge_report_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[9:0], m_tdata[19:10], m_tdata[29:20], m_tdata[39:30],
                   m_tdata[49:40], m_tdata[59:50], m_tdata[78:60], m_tdata[97:79], m_tuser};
            if (pending_reports.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_reports.pop_front();
                if (got != want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 49) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(5, 30);
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("** union_find_with_set_extrema: FAILED **");
            $finish;
        end
    end

    stim_row_t steps[] = '{
        '{10'd0,    10'd1023, 1'b1, '0},
        '{10'd1023, 10'd1023, 1'b1, '0},
        '{10'd5,    10'd5,    1'b1, '0},
        '{10'd682,  10'd341,  1'b1, '0},
        '{10'd0,    10'd1023, 1'b0, '0},
        '{10'd1023, 10'd2,    1'b0, '0},
        '{10'd3,    10'd4,    1'b0, '0},
        '{10'd4,    10'd2,    1'b0, '0},
        '{10'd682,  10'd3,    1'b0, '0},
        '{10'd0,    10'd341,  1'b0, '0},
        '{10'd6,    10'd7,    1'b0, '0},
        '{10'd7,    10'd6,    1'b0, '0},
        '{10'd8,    10'd9,    1'b0, '0},
        '{10'd9,    10'd6,    1'b0, '0},
        '{10'd1022, 10'd1021, 1'b0, '0}
    };

    initial begin
        int ln;
        logic [9:0] ea, eb;
        for (int i = 0; i < NE; i++) begin
            link_of[i] = 10'(i); members[i] = 11'd1; low_of[i] = 10'(i);
            high_of[i] = 10'(i); total_of[i] = 20'(i);
        end
        steps[0].rep = lone_pair(0, 1023, 0);
        // Element 0 now sits under 1023, so the set holds 0 and 1023.
        steps[1].rep = '{10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023,
                         19'd1023, 19'd1023, 1'b0};
        steps[2].rep = lone_pair(5, 5, 1);
        steps[3].rep = lone_pair(682, 341, 0);
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        foreach (steps[i]) send_merge(steps[i].ea, steps[i].eb, steps[i].fixed, steps[i].rep);
        // Random part: pairs within elements 0 to 63 build deep paths, whole-range pairs join
        // large sets, and requests with both indices equal hit repeats in the same set.
        for (int n = 0; n < NUM_RAND; n++) begin
            ln = $urandom_range(0, 9);
            if (ln < 5) begin
                ea = 10'($urandom_range(0, 63));
                eb = 10'($urandom_range(0, 63));
            end else if (ln < 9) begin
                ea = 10'($urandom);
                eb = 10'($urandom);
            end else begin
                ea = 10'($urandom);
                eb = ea;
            end
            send_merge(ea, eb, 1'b0, '0);
        end
        s_tvalid <= 0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0 && pending_reports.size() == 0)
            $display("** union_find_with_set_extrema: PASSED **");
        else
            $display("** union_find_with_set_extrema: FAILED **");
        $finish;
    end
endmodule
